// File: src/lpms_pkg.sv
// ----------------------------------------------------------------------------
// lpms_pkg: shared definitions for the linear partition core
// Constants, codes and status types used by the core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpms_pkg;

   // Default sizing of the carton store and of one carton size.
   localparam int DEF_MAX_CARTONS = 512;
   localparam int DEF_SIZE_BITS   = 24;

   // Fixed port widths.
   localparam int BOOKS_W  = 24;
   localparam int INDEX_W  = 9;
   localparam int VOL_W    = 10;
   localparam int BEST_W   = 33;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   // Register word index carried by paddr[2].
   localparam logic REG_VOLUNTEERS = 1'b0;
   localparam logic [VOL_W-1:0] VOLUNTEERS_RESET = VOL_W'(1);

   // Command codes.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Solver status seen by the top level.
   typedef struct packed {
      logic busy;   // sequencer is running
      logic done;   // one-cycle pulse at the end of a solve
      logic ok;     // last solve was feasible, marks are valid
   } solve_status_type;

endpackage

`default_nettype wire

// File: src/lpms_accum.sv
// ----------------------------------------------------------------------------
// lpms_accum: shared add and compare unit
// Adds two operands and flags when the sum exceeds a limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpms_accum #(
   parameter int W = 33
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] limit,
   output logic      [W:0]   sum,
   output logic              over
);

   assign sum  = {1'b0, a} + {1'b0, b};
   assign over = sum > {1'b0, limit};

endmodule

`default_nettype wire

// File: src/lpms_store.sv
// ----------------------------------------------------------------------------
// lpms_store: carton and part-end memories
// One write and one registered read port for each array; shared read address.
// ----------------------------------------------------------------------------
`default_nettype none

module lpms_store #(
   parameter int MAX_CARTONS = lpms_pkg::DEF_MAX_CARTONS,
   parameter int SIZE_BITS   = lpms_pkg::DEF_SIZE_BITS,
   localparam int AW         = $clog2(MAX_CARTONS)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [SIZE_BITS-1:0] wr_data,
   input  wire logic                 mark_we,
   input  wire logic [AW-1:0]        mark_waddr,
   input  wire logic                 mark_wdata,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [SIZE_BITS-1:0] rd_data,
   output logic                      mark_q
);

   logic [SIZE_BITS-1:0] carton_mem [MAX_CARTONS];
   logic                 mark_mem   [MAX_CARTONS];
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 mark_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         carton_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= carton_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_q_ff <= mark_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign mark_q  = mark_q_ff;

endmodule

`default_nettype wire

// File: src/lpms_solver.sv
// ----------------------------------------------------------------------------
// lpms_solver: solve sequencer
// Sums the cartons, binary-searches the target and places the part ends,
// streaming the store once per pass through one shared add and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpms_solver #(
   parameter int MAX_CARTONS = lpms_pkg::DEF_MAX_CARTONS,
   parameter int SIZE_BITS   = lpms_pkg::DEF_SIZE_BITS,
   localparam int AW         = $clog2(MAX_CARTONS),
   localparam int CW         = $clog2(MAX_CARTONS + 1),
   localparam int SW         = SIZE_BITS + AW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [CW-1:0]                 count,
   input  wire logic [lpms_pkg::VOL_W-1:0]    volunteers,
   input  wire logic [SIZE_BITS-1:0]          rd_data,
   input  wire logic                          mark_q,
   output logic      [AW-1:0]                 rd_addr,
   output logic                               mark_we,
   output logic      [AW-1:0]                 mark_waddr,
   output logic                               mark_wdata,
   output logic      [SW-1:0]                 best,
   output lpms_pkg::solve_status_type         status
);

   localparam int KW = (CW > lpms_pkg::VOL_W) ? CW : lpms_pkg::VOL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MID,
      ST_PROBE,
      ST_DECIDE,
      ST_BACK,
      ST_EXTRA
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] pidx_ff;
   logic [CW-1:0] left_ff;
   logic          pend_ff;
   logic          pend_last_ff;
   logic [SW-1:0] total_ff;
   logic [SW-1:0] big_ff;
   logic [SW-1:0] low_ff;
   logic [SW-1:0] high_ff;
   logic [SW-1:0] mid_ff;
   logic [SW-1:0] run_ff;
   logic [SW-1:0] best_ff;
   logic [CW-1:0] parts_ff;
   logic [CW-1:0] cuts_ff;
   logic          done_ff;
   logic          ok_ff;

   logic [SW-1:0] op_a;
   logic [SW-1:0] op_b;
   logic [SW-1:0] op_limit;
   logic [SW:0]   sum;
   logic          over;
   logic [SW-1:0] v;
   logic [SW-1:0] big_in;
   logic [SW-1:0] run_in;
   logic [CW-1:0] parts_in;
   logic [CW-1:0] cnt_m1;
   logic          streaming;
   logic          issue;
   logic          extra_ok;
   logic          no_solution;
   logic          done_in;

   lpms_accum #(.W(SW)) u_accum (
      .a     (op_a),
      .b     (op_b),
      .limit (op_limit),
      .sum   (sum),
      .over  (over)
   );

   always_comb begin
      v        = SW'(rd_data);
      big_in   = (v > big_ff) ? v : big_ff;
      run_in   = over ? v : sum[SW-1:0];
      parts_in = over ? parts_ff + 1'b1 : parts_ff;
      cnt_m1   = count - 1'b1;

      streaming = (state_ff == ST_SUM) || (state_ff == ST_PROBE) ||
                  (state_ff == ST_BACK) || (state_ff == ST_EXTRA);
      issue     = streaming && (left_ff != '0);

      // An extra part end goes on an unmarked entry while cuts + 1 < k.
      extra_ok = !mark_q &&
                 (((KW+1)'(cuts_ff) + (KW+1)'(1)) < (KW+1)'(volunteers));

      no_solution = (count == '0) || (volunteers == '0) ||
                    (KW'(volunteers) > KW'(count));

      // The solve ends right away when no split exists, else after the last
      // carton of the backward pass or of the extra-end pass.
      done_in = ((state_ff == ST_IDLE) && start && no_solution) ||
                (pend_ff && pend_last_ff &&
                 (((state_ff == ST_BACK) && (count <= CW'(1))) ||
                  (state_ff == ST_EXTRA)));

      unique case (state_ff)
         ST_SUM: begin
            op_a = total_ff; op_b = v; op_limit = '0;
         end
         ST_MID: begin
            op_a = low_ff; op_b = high_ff; op_limit = '0;
         end
         ST_PROBE: begin
            op_a = run_ff; op_b = v; op_limit = mid_ff;
         end
         ST_DECIDE: begin
            op_a = mid_ff; op_b = SW'(1); op_limit = '0;
         end
         ST_BACK: begin
            op_a = run_ff; op_b = v; op_limit = best_ff;
         end
         default: begin
            op_a = '0; op_b = '0; op_limit = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         done_ff      <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         done_ff      <= done_in;
         pend_ff      <= issue;
         pend_last_ff <= (left_ff == CW'(1));
         pidx_ff      <= idx_ff;
         if (issue) begin
            idx_ff  <= (state_ff == ST_BACK) ? idx_ff - 1'b1 : idx_ff + 1'b1;
            left_ff <= left_ff - 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (no_solution) begin
                     best_ff <= '0;
                     ok_ff   <= 1'b0;
                  end else begin
                     state_ff <= ST_SUM;
                     idx_ff   <= '0;
                     left_ff  <= count;
                     total_ff <= '0;
                     big_ff   <= '0;
                  end
               end
            end
            ST_SUM: begin
               if (pend_ff) begin
                  total_ff <= sum[SW-1:0];
                  big_ff   <= big_in;
                  if (pend_last_ff) begin
                     low_ff   <= big_in;
                     high_ff  <= sum[SW-1:0];
                     state_ff <= ST_MID;
                  end
               end
            end
            ST_MID: begin
               if (low_ff < high_ff) begin
                  mid_ff   <= sum[SW:1];
                  state_ff <= ST_PROBE;
                  idx_ff   <= '0;
                  left_ff  <= count;
                  run_ff   <= '0;
                  parts_ff <= CW'(1);
               end else begin
                  best_ff  <= low_ff;
                  state_ff <= ST_BACK;
                  idx_ff   <= cnt_m1[AW-1:0];
                  left_ff  <= count;
                  run_ff   <= '0;
                  cuts_ff  <= '0;
               end
            end
            ST_PROBE: begin
               if (pend_ff) begin
                  run_ff   <= run_in;
                  parts_ff <= parts_in;
                  if (pend_last_ff) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_DECIDE: begin
               if (KW'(parts_ff) <= KW'(volunteers)) begin
                  high_ff <= mid_ff;
               end else begin
                  low_ff <= sum[SW-1:0];
               end
               state_ff <= ST_MID;
            end
            ST_BACK: begin
               if (pend_ff) begin
                  run_ff <= run_in;
                  if (over) begin
                     cuts_ff <= cuts_ff + 1'b1;
                  end
                  if (pend_last_ff) begin
                     if (count > CW'(1)) begin
                        state_ff <= ST_EXTRA;
                        idx_ff   <= '0;
                        left_ff  <= cnt_m1;
                     end else begin
                        state_ff <= ST_IDLE;
                        ok_ff    <= 1'b1;
                     end
                  end
               end
            end
            ST_EXTRA: begin
               if (pend_ff) begin
                  if (extra_ok) begin
                     cuts_ff <= cuts_ff + 1'b1;
                  end
                  if (pend_last_ff) begin
                     state_ff <= ST_IDLE;
                     ok_ff    <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rd_addr    = idx_ff;
   assign mark_we    = pend_ff && ((state_ff == ST_BACK) ||
                                   ((state_ff == ST_EXTRA) && extra_ok));
   assign mark_waddr = pidx_ff;
   assign mark_wdata = (state_ff == ST_BACK) ? over : 1'b1;
   assign best       = best_ff;

   always_comb begin
      status.busy = (state_ff != ST_IDLE);
      status.done = done_ff;
      status.ok   = ok_ff;
   end

endmodule

`default_nettype wire

// File: src/linear_partition_min_max_sum_core.sv
// ----------------------------------------------------------------------------
// linear_partition_min_max_sum_core: minimum-largest-sum linear partition
// Loads cartons, splits them into k contiguous parts and reads them back.
// ----------------------------------------------------------------------------
// A command is transferred on a rising edge where start is high and busy is
// low. A load produces no result. A read produces its result in the
// cycle after the transfer, shown for exactly one cycle with rsp_strobe;
// the receiver cannot stall it, so it must take every result.
// Loads and reads can be issued every cycle while busy is low. A load
// flagged with req_last starts the solve, and busy stays high until it
// ends. For n loaded cartons the solve streams the store once to total the
// sizes, once per binary-search probe (one probe per halving of the span
// between the largest carton and the total, so at most about log2(total)
// probes), then in a backward pass and an extra-end pass to place the part
// ends; a solve whose k is zero or above n ends right away. The solve's
// pace is set by the single store read port and the one shared add and
// compare unit, each handling one carton per cycle. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_partition_min_max_sum_core #(
   parameter int MAX_CARTONS = lpms_pkg::DEF_MAX_CARTONS,
   parameter int SIZE_BITS   = lpms_pkg::DEF_SIZE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_command,
   input  wire logic [lpms_pkg::BOOKS_W-1:0]   req_books,
   input  wire logic                           req_last,
   input  wire logic [lpms_pkg::INDEX_W-1:0]   req_read_index,
   // result channel
   output logic                                rsp_strobe,
   output logic      [lpms_pkg::BOOKS_W-1:0]   rsp_entry_books,
   output logic                                rsp_ends_part,
   output logic      [lpms_pkg::BEST_W-1:0]    rsp_best_max,
   output logic                                rsp_infeasible,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [lpms_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [lpms_pkg::CSR_W-1:0]     pwdata,
   output logic      [lpms_pkg::CSR_W-1:0]     prdata,
   output logic                                pready
);

   localparam int AW   = $clog2(MAX_CARTONS);
   localparam int CW   = $clog2(MAX_CARTONS + 1);
   localparam int SW   = SIZE_BITS + AW;
   localparam int KW   = (CW > lpms_pkg::VOL_W) ? CW : lpms_pkg::VOL_W;
   localparam int IW   = (CW > lpms_pkg::INDEX_W) ? CW : lpms_pkg::INDEX_W;
   // Only the low bits of a size that both the port and the store carry count.
   localparam int KEEP = (SIZE_BITS < lpms_pkg::BOOKS_W) ? SIZE_BITS
                                                         : lpms_pkg::BOOKS_W;

   logic [lpms_pkg::VOL_W-1:0] volunteers_ff;
   logic [CW-1:0]              count_ff;
   logic                       solved_ff;
   logic                       start_ff;
   logic                       rsp_pend_ff;
   logic                       in_range_ff;
   logic                       feasible_ff;

   logic                       accept;
   logic                       load_xfer;
   logic                       read_xfer;
   logic                       csr_write;
   logic [CW-1:0]              count_base;
   logic                       has_room;
   logic                       feasible_now;
   logic                       in_range_now;

   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              solver_addr;
   logic [SIZE_BITS-1:0]       rd_data;
   logic                       mark_q;
   logic                       mark_we;
   logic [AW-1:0]              mark_waddr;
   logic                       mark_wdata;
   logic [SW-1:0]              best;
   lpms_pkg::solve_status_type status;

   // ---------------------------------------------------------------------
   // Command decode. busy also covers the cycle of the start request and
   // the cycle in which the solver reports completion, so a read never
   // samples stale solve state.
   // ---------------------------------------------------------------------
   assign busy      = start_ff | status.busy | status.done;
   assign accept    = start & ~busy;
   assign load_xfer = accept && (req_command == lpms_pkg::CMD_LOAD);
   assign read_xfer = accept && (req_command == lpms_pkg::CMD_READ);

   // A load after a finished solve opens a new sequence.
   assign count_base = solved_ff ? '0 : count_ff;
   assign has_room   = count_base < CW'(MAX_CARTONS);

   // A read reports marks and the optimum only for a solved, feasible split
   // under the part count that is set now.
   assign feasible_now = solved_ff && (count_ff != '0) &&
                         (volunteers_ff != '0) &&
                         (KW'(volunteers_ff) <= KW'(count_ff));
   assign in_range_now = IW'(req_read_index) < IW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         solved_ff   <= 1'b0;
         start_ff    <= 1'b0;
         rsp_pend_ff <= 1'b0;
      end else begin
         start_ff    <= load_xfer && req_last;
         rsp_pend_ff <= read_xfer;
         if (load_xfer) begin
            solved_ff <= 1'b0;
            count_ff  <= has_room ? count_base + 1'b1 : count_base;
         end else if (status.done) begin
            solved_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (read_xfer) begin
         in_range_ff <= in_range_now;
         feasible_ff <= feasible_now;
      end
   end

   // ---------------------------------------------------------------------
   // Register port: one word, the part count k.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == lpms_pkg::REG_VOLUNTEERS);

   always_ff @(posedge clock) begin
      if (reset) begin
         volunteers_ff <= lpms_pkg::VOLUNTEERS_RESET;
      end else if (csr_write) begin
         volunteers_ff <= pwdata[lpms_pkg::VOL_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == lpms_pkg::REG_VOLUNTEERS) begin
         prdata = lpms_pkg::CSR_W'(volunteers_ff);
      end else begin
         prdata = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Store and solver. The solver owns the read port while it runs.
   // ---------------------------------------------------------------------
   assign rd_addr = status.busy ? solver_addr : AW'(req_read_index);

   lpms_store #(
      .MAX_CARTONS (MAX_CARTONS),
      .SIZE_BITS   (SIZE_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (load_xfer && has_room),
      .wr_addr    (count_base[AW-1:0]),
      .wr_data    (SIZE_BITS'(req_books[KEEP-1:0])),
      .mark_we    (mark_we),
      .mark_waddr (mark_waddr),
      .mark_wdata (mark_wdata),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .mark_q     (mark_q)
   );

   lpms_solver #(
      .MAX_CARTONS (MAX_CARTONS),
      .SIZE_BITS   (SIZE_BITS)
   ) u_solver (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .count      (count_ff),
      .volunteers (volunteers_ff),
      .rd_data    (rd_data),
      .mark_q     (mark_q),
      .rd_addr    (solver_addr),
      .mark_we    (mark_we),
      .mark_waddr (mark_waddr),
      .mark_wdata (mark_wdata),
      .best       (best),
      .status     (status)
   );

   // ---------------------------------------------------------------------
   // Result: driven from the registered store outputs in the cycle after the
   // read transfer.
   // ---------------------------------------------------------------------
   assign rsp_strobe      = rsp_pend_ff;
   assign rsp_entry_books = in_range_ff ? lpms_pkg::BOOKS_W'(rd_data) : '0;
   assign rsp_ends_part   = in_range_ff && feasible_ff && status.ok && mark_q;
   assign rsp_best_max    = feasible_ff ? lpms_pkg::BEST_W'(best) : '0;
   assign rsp_infeasible  = !feasible_ff;

endmodule

`default_nettype wire

// File: src/lpms_checker.sv
// ----------------------------------------------------------------------------
// lpms_checker: port-level checks for the linear partition core
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpms_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_command,
   input wire logic                          req_last,
   input wire logic                          rsp_strobe,
   input wire logic                          rsp_ends_part,
   input wire logic [lpms_pkg::BEST_W-1:0]   rsp_best_max,
   input wire logic                          rsp_infeasible
);

   logic read_xfer;
   logic last_load_xfer;

   assign read_xfer      = start && !busy && (req_command == lpms_pkg::CMD_READ);
   assign last_load_xfer = start && !busy && (req_command == lpms_pkg::CMD_LOAD) &&
                           req_last;

   // Every read transfer yields exactly one result in the next cycle.
   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      read_xfer |=> rsp_strobe)
      else $error("read transfer without a result");

   a_result_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(read_xfer))
      else $error("result without a read transfer");

   // The final load must hold off further commands while the solve runs.
   a_last_starts_solve: assert property (@(posedge clock) disable iff (reset)
      last_load_xfer |=> busy)
      else $error("final load did not start a solve");

   // An infeasible result carries no optimum and no part ends.
   a_infeasible_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_infeasible) |-> ((rsp_best_max == '0) && !rsp_ends_part))
      else $error("infeasible result carries data");

endmodule

bind linear_partition_min_max_sum_core lpms_checker u_lpms_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_command    (req_command),
   .req_last       (req_last),
   .rsp_strobe     (rsp_strobe),
   .rsp_ends_part  (rsp_ends_part),
   .rsp_best_max   (rsp_best_max),
   .rsp_infeasible (rsp_infeasible)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for linear_partition_min_max_sum_core
// Loads carton sequences, lets the core split them into k contiguous parts,
// reads every kind of entry back and checks each read result against an
// in-bench partition solver. The part count register is swept through
// ordinary values and its extremes between phases of differing sender gaps.
// ----------------------------------------------------------------------------

module tb;

   localparam int BOOKS_W = lpms_pkg::BOOKS_W;
   localparam int INDEX_W = lpms_pkg::INDEX_W;
   localparam int BEST_W  = lpms_pkg::BEST_W;
   localparam int VOL_W   = lpms_pkg::VOL_W;
   localparam int CSR_W   = lpms_pkg::CSR_W;
   localparam int CSR_AW  = lpms_pkg::CSR_AW;

   localparam int unsigned SHELF_DEPTH   = lpms_pkg::DEF_MAX_CARTONS;
   localparam int unsigned BOOKS_MAX     = 9999999;
   localparam int unsigned INDEX_MAX     = (1 << INDEX_W) - 1;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_BUDGET  = 300;

   // One command as it sits in the sender's queue. A command flagged with
   // drain_first is held back until every read result already owed has come.
   typedef struct packed {
      logic               command;
      logic [BOOKS_W-1:0] books;
      logic               last;
      logic [INDEX_W-1:0] read_index;
      logic               drain_first;
   } carton_cmd_type;

   // What one read must return.
   typedef struct packed {
      logic [BOOKS_W-1:0] entry_books;
      logic               ends_part;
      logic [BEST_W-1:0]  best_max;
      logic               infeasible;
   } entry_report_type;

   // Every input of the core starts at a known value.
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic                req_command    = lpms_pkg::CMD_LOAD;
   logic [BOOKS_W-1:0]  req_books      = '0;
   logic                req_last       = 1'b0;
   logic [INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_strobe;
   logic [BOOKS_W-1:0]  rsp_entry_books;
   logic                rsp_ends_part;
   logic [BEST_W-1:0]   rsp_best_max;
   logic                rsp_infeasible;
   logic                psel           = 1'b0;
   logic                penable        = 1'b0;
   logic                pwrite         = 1'b0;
   logic [CSR_AW-1:0]   paddr          = '0;
   logic [CSR_W-1:0]    pwdata         = '0;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // Solver state kept by the bench: the loaded cartons, the part ends of the
   // last solve, the optimum and the part count currently programmed.
   logic [BOOKS_W-1:0]  shelf [SHELF_DEPTH];
   logic                cut_after [SHELF_DEPTH];
   int unsigned         shelf_count = 0;
   logic [BEST_W-1:0]   best_sum    = '0;
   logic                solved      = 1'b0;
   logic [VOL_W-1:0]    part_goal   = lpms_pkg::VOLUNTEERS_RESET;

   carton_cmd_type      carton_cmds [$];
   entry_report_type    reports_due [$];
   carton_cmd_type      on_wire;

   int unsigned         gap_pct         = 0;
   int unsigned         no_gap_run      = 0;
   int unsigned         items_queued    = 0;
   int unsigned         mismatches      = 0;
   int unsigned         loads_taken     = 0;
   int unsigned         reads_taken     = 0;
   int unsigned         solves_run      = 0;
   int unsigned         feasible_solves = 0;
   int unsigned         reports_checked = 0;

   linear_partition_min_max_sum_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_books       (req_books),
      .req_last        (req_last),
      .req_read_index  (req_read_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_entry_books (rsp_entry_books),
      .rsp_ends_part   (rsp_ends_part),
      .rsp_best_max    (rsp_best_max),
      .rsp_infeasible  (rsp_infeasible),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Partition solver
   // ------------------------------------------------------------------------

   // Number of parts a greedy left-to-right fill needs when no part may
   // exceed the given target.
   function automatic int unsigned parts_at(input longint unsigned target);
      int unsigned     parts = 1;
      longint unsigned run   = 0;
      longint unsigned v;
      for (int unsigned i = 0; i < shelf_count; i++) begin
         v = shelf[i];
         if (run + v > target) begin
            parts++;
            run = v;
         end else begin
            run += v;
         end
      end
      return parts;
   endfunction

   // Binary search of the smallest feasible target, then part ends placed by
   // a greedy pass from the tail. Missing part ends are added after the
   // earliest unmarked entries so that the leading parts stay lightest.
   task automatic solve_partition();
      longint unsigned total   = 0;
      longint unsigned biggest = 0;
      longint unsigned run     = 0;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned v;
      int unsigned     cuts    = 0;
      foreach (cut_after[j]) cut_after[j] = 1'b0;
      best_sum = '0;
      solved   = 1'b1;
      solves_run++;
      // An empty shelf, a part count of zero or more parts than cartons all
      // leave the optimum at zero with no part ends.
      if (shelf_count == 0 || part_goal == 0 || part_goal > shelf_count) return;
      feasible_solves++;
      for (int unsigned i = 0; i < shelf_count; i++) begin
         total += shelf[i];
         if (shelf[i] > biggest) biggest = shelf[i];
      end
      lo = biggest;
      hi = total;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (parts_at(mid) <= part_goal) hi = mid;
         else lo = mid + 1;
      end
      best_sum = lo[BEST_W-1:0];
      for (int unsigned i = shelf_count; i > 0; i--) begin
         v = shelf[i-1];
         if (run + v > lo) begin
            cut_after[i-1] = 1'b1;
            cuts++;
            run = v;
         end else begin
            run += v;
         end
      end
      for (int unsigned i = 0; i + 1 < shelf_count && cuts + 1 < part_goal; i++) begin
         if (!cut_after[i]) begin
            cut_after[i] = 1'b1;
            cuts++;
         end
      end
   endtask

   // Applies one transferred command to the bench state. A read queues the
   // report that the core owes for it.
   task automatic apply_carton_cmd(input carton_cmd_type c);
      entry_report_type r;
      logic             feasible;
      if (c.command == lpms_pkg::CMD_LOAD) begin
         loads_taken++;
         // The first load after a solve opens a new sequence.
         if (solved) begin
            shelf_count = 0;
            foreach (cut_after[j]) cut_after[j] = 1'b0;
            best_sum = '0;
            solved   = 1'b0;
         end
         // Once the store is full further cartons are dropped, but a last
         // flag on one of them still starts the solve.
         if (shelf_count < SHELF_DEPTH) begin
            shelf[shelf_count] = c.books;
            shelf_count++;
         end
         if (c.last) solve_partition();
      end else begin
         reads_taken++;
         // Feasibility is judged against the part count programmed now, so a
         // register change after a solve shows up on the next read.
         feasible = solved && shelf_count != 0 && part_goal != 0 &&
                    part_goal <= shelf_count;
         r.entry_books = '0;
         r.ends_part   = 1'b0;
         if (c.read_index < shelf_count) begin
            r.entry_books = shelf[c.read_index];
            if (feasible) r.ends_part = cut_after[c.read_index];
         end
         r.best_max   = feasible ? best_sum : '0;
         r.infeasible = !feasible;
         reports_due = {reports_due, r};
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Command driver
   // ------------------------------------------------------------------------
   // A command is presented with start high and held until the edge at which
   // busy is low; that edge is the transfer. Only then is the next command, or
   // a gap, chosen. Gaps are drawn at gap_pct percent, broken by occasional
   // runs with no gaps at all.
   always @(posedge clock) begin : drive_cmds
      logic took;
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && busy === 1'b0;
         if (took) apply_carton_cmd(on_wire);
         if (!start || took) begin
            go = 1'b0;
            if (carton_cmds.size() != 0 &&
                !(carton_cmds[0].drain_first && reports_due.size() != 0)) begin
               if (no_gap_run != 0) begin
                  go = 1'b1;
                  no_gap_run--;
               end else if ($urandom_range(99) >= gap_pct) begin
                  go = 1'b1;
                  if ($urandom_range(99) < 4) no_gap_run = $urandom_range(40, 8);
               end
            end
            if (go) begin
               on_wire         = carton_cmds.pop_front();
               start          <= 1'b1;
               req_command    <= on_wire.command;
               req_books      <= on_wire.books;
               req_last       <= on_wire.last;
               req_read_index <= on_wire.read_index;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------
   // Each read result is on the ports for one cycle and is taken at the edge
   // that ends it; it is matched against the oldest owed report.
   always @(posedge clock) begin : watch_reports
      entry_report_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (reports_due.size() == 0) begin
            $error("Read result transferred with no read outstanding");
            mismatches++;
         end else begin
            want = reports_due.pop_front();
            reports_checked++;
            check_field("entry_books", want.entry_books, rsp_entry_books);
            check_field("ends_part",   want.ends_part,   rsp_ends_part);
            check_field("best_max",    want.best_max,    rsp_best_max);
            check_field("infeasible",  want.infeasible,  rsp_infeasible);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Fields that a command does not use still carry random values.
   task automatic queue_load(input int unsigned books, input logic last_flag);
      carton_cmd_type c;
      c.command     = lpms_pkg::CMD_LOAD;
      c.books       = BOOKS_W'(books);
      c.last        = last_flag;
      c.read_index  = INDEX_W'($urandom);
      c.drain_first = 1'b0;
      carton_cmds   = {carton_cmds, c};
      items_queued++;
   endtask

   task automatic queue_read(input int unsigned idx, input logic drain);
      carton_cmd_type c;
      c.command     = lpms_pkg::CMD_READ;
      c.books       = BOOKS_W'($urandom_range(BOOKS_MAX, 1));
      c.last        = 1'($urandom);
      c.read_index  = INDEX_W'(idx);
      c.drain_first = drain;
      carton_cmds   = {carton_cmds, c};
      items_queued++;
   endtask

   // Waits until all commands are transferred, every report has come and the
   // core has gone idle. A final load causes no report but starts a solve, so
   // busy is checked once more after a settling wait.
   task automatic finish_phase();
      do @(posedge clock);
      while (carton_cmds.size() != 0 || start !== 1'b0 || reports_due.size() != 0 ||
             busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Programs the part count while the core is idle and reads it back.
   task automatic write_part_goal(input int unsigned value);
      logic [CSR_W-1:0] readback;
      finish_phase();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {lpms_pkg::REG_VOLUNTEERS, 2'b00};
      pwdata  <= CSR_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      part_goal = VOL_W'(value);
      // Back-to-back read of the same register.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      check_field("volunteers", CSR_W'(part_goal), readback);
   endtask

   // One carton sequence with random content followed by reads. A small share
   // is broken: the last flag is left off, so the next sequence appends. Stray
   // reads also land between loads before the solve.
   task automatic queue_job(input int unsigned n, input int unsigned style);
      logic        drop_last;
      int unsigned value;
      int unsigned pick;
      int unsigned idx;
      int unsigned reads;
      drop_last = $urandom_range(99) < 8;
      for (int unsigned i = 0; i < n; i++) begin
         case (style)
            0:       value = $urandom_range(15, 1);
            1:       value = $urandom_range(BOOKS_MAX, 1);
            2:       value = BOOKS_MAX;
            default: value = ($urandom_range(3) == 0) ?
                             $urandom_range(BOOKS_MAX, 5000000) : $urandom_range(100, 1);
         endcase
         queue_load(value, i + 1 == n && !drop_last);
         if ($urandom_range(99) < 6) queue_read($urandom_range(n), 1'b0);
      end
      if ($urandom_range(2) == 0) begin
         for (int unsigned i = 0; i < n; i++) queue_read(i, 1'b0);
      end
      reads = $urandom_range(n + 3, 1);
      for (int unsigned i = 0; i < reads; i++) begin
         pick = $urandom_range(99);
         if (pick < 70)      idx = $urandom_range(n - 1, 0);
         else if (pick < 90) idx = $urandom_range(INDEX_MAX, 0);
         else                idx = n;
         queue_read(idx, $urandom_range(99) < 4);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_start;
      int unsigned group;
      int unsigned goal;
      int unsigned pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, part count still at its reset value of one. Reads
      // before any load, a read before the solve, the largest carton, the
      // highest bit of the size field, and reads past the end.
      queue_read(0, 1'b0);
      queue_read(INDEX_MAX, 1'b0);
      queue_load(1, 1'b0);
      queue_load(BOOKS_MAX, 1'b0);
      queue_read(1, 1'b0);
      queue_load(24'h800000, 1'b1);
      for (int unsigned i = 0; i < 4; i++) queue_read(i, 1'b0);

      // Three parts over four cartons where the tail-first greedy pass gives
      // too few ends, so extra ends go after the earliest entries. The last
      // read waits until the earlier reports have drained.
      write_part_goal(3);
      queue_load(5, 1'b0);
      queue_load(1, 1'b0);
      queue_load(1, 1'b0);
      queue_load(1, 1'b1);
      for (int unsigned i = 0; i < 4; i++) queue_read(i, i == 3);
      // A new sequence of one carton cannot be split into three parts.
      queue_load(2, 1'b1);
      queue_read(0, 1'b0);

      // A part count of zero is infeasible. Changing it afterwards alters
      // feasibility on the next read but not the stored optimum.
      write_part_goal(0);
      queue_load(7, 1'b1);
      queue_read(0, 1'b0);
      write_part_goal(1);
      queue_read(0, 1'b0);

      // Full store: two loads past the depth are dropped and the last of
      // them starts the solve. All cartons at the maximum with one part push
      // the optimum past 32 bits.
      write_part_goal(1);
      for (int unsigned i = 0; i < SHELF_DEPTH + 2; i++) begin
         queue_load(BOOKS_MAX, i == SHELF_DEPTH + 1);
      end
      queue_read(0, 1'b0);
      queue_read(SHELF_DEPTH - 1, 1'b0);
      queue_read(1, 1'b1);
      for (int unsigned i = 0; i < 8; i++) queue_read($urandom_range(INDEX_MAX, 0), 1'b0);

      // Random part, in three phases of sender gaps: none, 63 and 10 percent.
      // The receiver cannot hold results off, so only the sender idles.
      for (int unsigned p = 0; p < 3; p++) begin
         finish_phase();
         gap_pct     = (p == 0) ? 0 : (p == 1) ? 63 : 10;
         phase_start = items_queued;
         group       = 0;
         while (items_queued - phase_start < PHASE_BUDGET) begin
            if (group == 0 && p == 1) begin
               goal = SHELF_DEPTH;
            end else if (group == 0 && p == 2) begin
               goal = (1 << VOL_W) - 1;
            end else begin
               pick = $urandom_range(99);
               if (pick < 10)      goal = 1;
               else if (pick < 14) goal = 0;
               else if (pick < 17) goal = SHELF_DEPTH;
               else if (pick < 70) goal = $urandom_range(6, 2);
               else                goal = $urandom_range(24, 1);
            end
            write_part_goal(goal);
            repeat ($urandom_range(3, 1)) begin
               queue_job(($urandom_range(99) < 80) ? $urandom_range(12, 1) :
                         $urandom_range(40, 13), $urandom_range(3));
            end
            group++;
         end
      end
      finish_phase();

      $display("Ran %0d commands (%0d loads, %0d reads) through %0d solves, %0d feasible.",
               loads_taken + reads_taken, loads_taken, reads_taken, solves_run,
               feasible_solves);
      $display("Checked %0d read results over part counts from 0 to 1023 and a full store.",
               reports_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $error("Run did not complete in the allotted time");
      $display("Mismatches found");
      $finish;
   end

endmodule
